// ----- rtl/pce_pkg.sv -----
`default_nettype none
package pce_pkg;

  localparam int SAMPLE_W = 16;

  // config register file
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_SUBCARRIER_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SYMBOL_COUNT     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MMSE_ENABLE      = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_NOISE_LEVEL      = 2'd3;

  localparam logic [12:0] SC_COUNT_RESET  = 13'd12;
  localparam logic [3:0]  SYM_COUNT_RESET = 4'd14;
  localparam logic [12:0] MAX_SC  = 13'd4096;
  localparam logic [3:0]  MAX_SYM = 4'd14;

  localparam logic [15:0] WEIGHT_ONE  = 16'd32768;
  localparam logic [15:0] LS_VARIANCE = 16'd256;

  // bit-serial multiplier: A x B, one B bit per cycle while ctl.step is high
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // restoring divider: one quotient bit per cycle while ctl.step is high
  localparam int DIV_N_W = MUL_P_W;
  localparam int DIV_D_W = 34;
  localparam int DIV_Q_W = 17;

  // rounded quotient limits, Q3.12 output
  localparam logic [DIV_Q_W-1:0] EST_POS_LIM = 17'd32767;
  localparam logic [DIV_Q_W-1:0] EST_NEG_LIM = 17'd32768;

  typedef struct packed {
    logic load;
    logic step;
  } unit_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/pilot_channel_estimator_core.sv -----
// An accepted word passes S_MUL1 (first bit-serial products and weight division),
// S_SUM (sum), S_MUL2 (weighted products), S_DLOAD (divider load), S_DIV (quotient
// bits) and S_OUT (output hand-off), then S_IDLE; a zero-power pilot goes from S_SUM
// straight to S_OUT. A new word is taken only in S_IDLE, once the last is handed off.
// A result waits in the output register while the next word is processed; S_OUT holds.
// Reset (rst, synchronous): config registers to defaults, grid counters to zero,
`default_nettype none
module pilot_channel_estimator_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [pce_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [pce_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // tx_real, tx_imag, rx_real, rx_imag
  input  wire logic [63:0]                    s_tdata,
  // last_pilot
  input  wire logic                           s_tlast,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // est_real, est_imag, subcarrier_index, symbol_index, grid_index, noise_variance
  output logic      [79:0]                    m_tdata,
  // written, saturated
  output logic      [1:0]                     m_tuser
);
  // (reset, continued) MMSE weight to one, control idle and output empty.
  import pce_pkg::*;

  localparam int NLANE = 6;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL1  = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_MUL2  = 3'd3;
  localparam logic [2:0] S_DLOAD = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [4:0] MUL_LAST = 5'(MUL_B_W - 1);
  localparam logic [4:0] DIV_LAST = 5'(DIV_Q_W - 1);

  // config
  logic [12:0] subcarrier_count;
  logic [3:0]  symbol_count;
  logic        mmse_enable;
  logic [15:0] noise_level;

  logic [2:0]  state;
  logic [4:0]  cnt;
  logic        accept;
  logic        mmse_act;
  logic [3:0]  xsign;
  logic [31:0] den;
  logic        zero_pwr;
  logic        neg_r;
  logic        neg_i;
  logic [15:0] weight;

  logic [15:0] mag_xr, mag_xi, mag_yr, mag_yi;

  unit_ctl_t          lane_ctl [NLANE];
  logic [MUL_A_W-1:0] lane_a   [NLANE];
  logic [MUL_B_W-1:0] lane_b   [NLANE];
  logic [MUL_P_W-1:0] lane_p   [NLANE];

  unit_ctl_t          div_ctl [2];
  logic [DIV_N_W-1:0] div_n   [2];
  logic [DIV_D_W-1:0] div_d   [2];
  logic [DIV_Q_W-1:0] div_q   [2];
  logic               div_ovf [2];

  logic [32:0] t2, t3, t4, t5, nr, ni;
  logic [31:0] mag_r, mag_i, den_sum;
  logic [17:0] wt_sum;
  logic [15:0] wt_new, w_sel;

  logic [11:0] pos_sc;
  logic [3:0]  pos_sy;
  logic [15:0] pos_grid;

  logic [15:0] est_real, est_imag, noise_variance;
  logic [11:0] subcarrier_index;
  logic [3:0]  symbol_index;
  logic [15:0] grid_index;
  logic        written, saturated;
  logic [16:0] rs_r, rs_i;
  logic        out_free;

  function automatic logic [16:0] round_sat(input logic [DIV_Q_W-1:0] q,
                                            input logic ovf, input logic neg);
    logic [DIV_Q_W:0]   sum;
    logic [DIV_Q_W-1:0] rnd;
    logic               sat;
    logic [15:0]        val;
    sum = {1'b0, q} + 18'd1;
    rnd = sum[DIV_Q_W:1];
    if (neg) begin
      sat = ovf | (rnd > EST_NEG_LIM);
      val = sat ? 16'h8000 : (~rnd[15:0] + 16'd1);
    end else begin
      sat = ovf | (rnd > EST_POS_LIM);
      val = sat ? 16'h7fff : rnd[15:0];
    end
    return {sat, val};
  endfunction

  assign s_tready = (state == S_IDLE) & ~rst;
  assign accept   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      subcarrier_count <= SC_COUNT_RESET;
      symbol_count     <= SYM_COUNT_RESET;
      mmse_enable      <= 1'b0;
      noise_level      <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SUBCARRIER_COUNT: subcarrier_count <= cfg_data[12:0];
        REG_SYMBOL_COUNT:     symbol_count     <= cfg_data[3:0];
        REG_MMSE_ENABLE:      mmse_enable      <= cfg_data[0];
        REG_NOISE_LEVEL:      noise_level      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    mag_xr = s_tdata[15]  ? (~s_tdata[15:0]  + 16'd1) : s_tdata[15:0];
    mag_xi = s_tdata[31]  ? (~s_tdata[31:16] + 16'd1) : s_tdata[31:16];
    mag_yr = s_tdata[47]  ? (~s_tdata[47:32] + 16'd1) : s_tdata[47:32];
    mag_yi = s_tdata[63]  ? (~s_tdata[63:48] + 16'd1) : s_tdata[63:48];
  end

  // numerators and power from the first multiplier pass, rounded MMSE weight from the divider
  always_comb begin
    t2      = {2'b0, lane_p[2][30:0]};
    t3      = {2'b0, lane_p[3][30:0]};
    t4      = {2'b0, lane_p[4][30:0]};
    t5      = {2'b0, lane_p[5][30:0]};
    t2      = xsign[0] ? (33'd0 - t2) : t2;
    t3      = xsign[1] ? (33'd0 - t3) : t3;
    t4      = xsign[2] ? (33'd0 - t4) : t4;
    t5      = xsign[3] ? (33'd0 - t5) : t5;
    nr      = t2 + t3;
    ni      = t4 - t5;
    mag_r   = nr[32] ? 32'(33'd0 - nr) : nr[31:0];
    mag_i   = ni[32] ? 32'(33'd0 - ni) : ni[31:0];
    den_sum = lane_p[0][31:0] + lane_p[1][31:0];
    wt_sum  = {1'b0, div_q[0]} + 18'd1;
    wt_new  = wt_sum[16:1];
    w_sel   = mmse_act ? wt_new : WEIGHT_ONE;
  end

  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      lane_ctl[k] = '0;
      lane_a[k]   = '0;
      lane_b[k]   = '0;
    end
    for (int k = 0; k < 2; k++) begin
      div_ctl[k] = '0;
      div_n[k]   = '0;
      div_d[k]   = '0;
    end
    case (state)
      S_IDLE: begin
        for (int k = 0; k < NLANE; k++) lane_ctl[k].load = accept;
        lane_a[0] = {16'b0, mag_xr}; lane_b[0] = mag_xr;
        lane_a[1] = {16'b0, mag_xi}; lane_b[1] = mag_xi;
        lane_a[2] = {16'b0, mag_yr}; lane_b[2] = mag_xr;
        lane_a[3] = {16'b0, mag_yi}; lane_b[3] = mag_xi;
        lane_a[4] = {16'b0, mag_yi}; lane_b[4] = mag_xr;
        lane_a[5] = {16'b0, mag_yr}; lane_b[5] = mag_xi;
        // MMSE weight: 2^24 / (256 + noise_level), then halved with rounding
        div_ctl[0].load = accept;
        div_n[0] = DIV_N_W'(1) << 24;
        div_d[0] = DIV_D_W'(noise_level) + DIV_D_W'(LS_VARIANCE);
      end
      S_MUL1: begin
        for (int k = 0; k < NLANE; k++) lane_ctl[k].step = ~cnt[4];
        div_ctl[0].step = 1'b1;
      end
      S_SUM: begin
        lane_ctl[0].load = 1'b1; lane_a[0] = mag_r; lane_b[0] = w_sel;
        lane_ctl[1].load = 1'b1; lane_a[1] = mag_i; lane_b[1] = w_sel;
      end
      S_MUL2: begin
        lane_ctl[0].step = 1'b1;
        lane_ctl[1].step = 1'b1;
      end
      S_DLOAD: begin
        for (int k = 0; k < 2; k++) begin
          div_ctl[k].load = 1'b1;
          div_n[k] = lane_p[k];
          div_d[k] = {den, 2'b00};
        end
      end
      S_DIV: begin
        div_ctl[0].step = 1'b1;
        div_ctl[1].step = 1'b1;
      end
      default: ;
    endcase
  end

  for (genvar g = 0; g < NLANE; g++) begin : g_lane
    pce_serial_mul u_mul (
      .clk     (clk),
      .ctl     (lane_ctl[g]),
      .a       (lane_a[g]),
      .b       (lane_b[g]),
      .product (lane_p[g])
    );
  end

  for (genvar g = 0; g < 2; g++) begin : g_div
    pce_serial_div u_div (
      .clk (clk),
      .ctl (div_ctl[g]),
      .n   (div_n[g]),
      .d   (div_d[g]),
      .q   (div_q[g]),
      .ovf (div_ovf[g])
    );
  end

  pce_position u_pos (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .last             (s_tlast),
    .subcarrier_count (subcarrier_count),
    .symbol_count     (symbol_count),
    .subcarrier_index (pos_sc),
    .symbol_index     (pos_sy),
    .grid_index       (pos_grid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      weight <= WEIGHT_ONE;
    end else begin
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (accept) state <= S_MUL1;
        end
        S_MUL1: begin
          cnt <= cnt + 5'd1;
          if (cnt == DIV_LAST) state <= S_SUM;
        end
        S_SUM: begin
          cnt <= '0;
          if (mmse_act) weight <= wt_new;
          state <= (den_sum == '0) ? S_OUT : S_MUL2;
        end
        S_MUL2: begin
          cnt <= cnt + 5'd1;
          if (cnt == MUL_LAST) state <= S_DLOAD;
        end
        S_DLOAD: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 5'd1;
          if (cnt == DIV_LAST) state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mmse_act <= mmse_enable & (noise_level != '0);
      xsign    <= {s_tdata[47] ^ s_tdata[31], s_tdata[63] ^ s_tdata[15],
                   s_tdata[63] ^ s_tdata[31], s_tdata[47] ^ s_tdata[15]};
    end
    if (state == S_SUM) begin
      den      <= den_sum;
      zero_pwr <= (den_sum == '0);
      neg_r    <= nr[32];
      neg_i    <= ni[32];
    end
  end

  assign rs_r = round_sat(div_q[0], div_ovf[0], neg_r);
  assign rs_i = round_sat(div_q[1], div_ovf[1], neg_i);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      written          <= ~zero_pwr;
      est_real         <= zero_pwr ? '0 : rs_r[15:0];
      est_imag         <= zero_pwr ? '0 : rs_i[15:0];
      saturated        <= ~zero_pwr & (rs_r[16] | rs_i[16]);
      noise_variance   <= zero_pwr ? '0 : (mmse_act ? noise_level : LS_VARIANCE);
      subcarrier_index <= pos_sc;
      symbol_index     <= pos_sy;
      grid_index       <= pos_grid;
    end
  end

  assign m_tdata = {noise_variance, grid_index, symbol_index, subcarrier_index,
                    est_imag, est_real};
  assign m_tuser = {saturated, written};

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_MUL1)
    else $error("accepted word did not start the multiplier pass");

  a_zero_power_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[31:0] == '0 && m_tdata[79:64] == '0
                                   && !m_tuser[1]))
    else $error("zero-power pilot carries a nonzero estimate");

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    weight != '0 && weight <= WEIGHT_ONE)
    else $error("MMSE weight out of range");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL2) |-> cnt <= MUL_LAST)
    else $error("second multiplier pass overran");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && $past(state) != S_IDLE) |-> $stable(xsign))
    else $error("input signs changed while a word is in flight");

endmodule
`default_nettype wire

// ----- rtl/pce_serial_mul.sv -----
`default_nettype none
module pce_serial_mul (
  input  wire logic                        clk,
  input  wire pce_pkg::unit_ctl_t          ctl,
  input  wire logic [pce_pkg::MUL_A_W-1:0] a,
  input  wire logic [pce_pkg::MUL_B_W-1:0] b,
  output logic      [pce_pkg::MUL_P_W-1:0] product
);
  import pce_pkg::*;

  logic [MUL_A_W-1:0] a_reg;
  logic [MUL_B_W-1:0] b_sh;
  logic [MUL_P_W-1:0] acc;
  logic [MUL_A_W:0]   psum;

  assign psum = {1'b0, acc[MUL_P_W-1:MUL_B_W]} + (b_sh[0] ? {1'b0, a_reg} : '0);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_reg <= a;
      b_sh  <= b;
      acc   <= '0;
    end else if (ctl.step) begin
      b_sh <= b_sh >> 1;
      acc  <= {psum, acc[MUL_B_W-1:1]};
    end
  end

  assign product = acc;

endmodule
`default_nettype wire

// ----- rtl/pce_serial_div.sv -----
`default_nettype none
module pce_serial_div (
  input  wire logic                        clk,
  input  wire pce_pkg::unit_ctl_t          ctl,
  input  wire logic [pce_pkg::DIV_N_W-1:0] n,
  input  wire logic [pce_pkg::DIV_D_W-1:0] d,
  output logic      [pce_pkg::DIV_Q_W-1:0] q,
  output logic                             ovf
);
  import pce_pkg::*;

  localparam int HI_W = DIV_N_W - DIV_Q_W;

  logic [DIV_D_W-1:0] d_reg;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_Q_W-1:0] nlow;
  logic [DIV_D_W:0]   trial;
  logic [DIV_D_W:0]   diff;
  logic               ge;

  assign trial = {rem, nlow[DIV_Q_W-1]};
  assign diff  = trial - {1'b0, d_reg};
  assign ge    = trial >= {1'b0, d_reg};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      d_reg <= d;
      rem   <= DIV_D_W'(n[DIV_N_W-1:DIV_Q_W]);
      nlow  <= n[DIV_Q_W-1:0];
      q     <= '0;
      // quotient would not fit in DIV_Q_W bits
      ovf   <= {{(DIV_D_W-HI_W){1'b0}}, n[DIV_N_W-1:DIV_Q_W]} >= d;
    end else if (ctl.step) begin
      rem  <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      nlow <= nlow << 1;
      q    <= {q[DIV_Q_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pce_position.sv -----
`default_nettype none
module pce_position (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic        last,
  input  wire logic [12:0] subcarrier_count,
  input  wire logic [3:0]  symbol_count,
  output logic      [11:0] subcarrier_index,
  output logic      [3:0]  symbol_index,
  output logic      [15:0] grid_index
);
  import pce_pkg::*;

  logic [11:0] sc_cnt;
  logic [3:0]  sy_cnt;
  logic [12:0] sc_n;
  logic [3:0]  sy_n;
  logic [11:0] sc_cur;
  logic [3:0]  sy_cur;
  logic [12:0] sc_inc;
  logic [3:0]  sy_inc;
  logic [15:0] grid;

  always_comb begin
    sc_n = subcarrier_count;
    if (subcarrier_count == '0) sc_n = 13'd1;
    else if (subcarrier_count > MAX_SC) sc_n = MAX_SC;
    sy_n = symbol_count;
    if (symbol_count == '0) sy_n = 4'd1;
    else if (symbol_count > MAX_SYM) sy_n = MAX_SYM;
    sc_cur = ({1'b0, sc_cnt} >= sc_n) ? '0 : sc_cnt;
    sy_cur = (sy_cnt >= sy_n) ? '0 : sy_cnt;
    sc_inc = {1'b0, sc_cur} + 13'd1;
    sy_inc = sy_cur + 4'd1;
    grid   = ({4'b0, sc_cur} * {12'b0, sy_n}) + {12'b0, sy_cur};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_cnt <= '0;
      sy_cnt <= '0;
    end else if (accept) begin
      if (last) begin
        sc_cnt <= '0;
        sy_cnt <= '0;
      end else if (sc_inc >= sc_n) begin
        sc_cnt <= '0;
        sy_cnt <= (sy_inc >= sy_n) ? '0 : sy_inc;
      end else begin
        sc_cnt <= sc_inc[11:0];
        sy_cnt <= sy_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      subcarrier_index <= sc_cur;
      symbol_index     <= sy_cur;
      grid_index       <= grid;
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/pilot_channel_estimator_core_tb.sv -----
`default_nettype none
module pilot_channel_estimator_core_tb;

  localparam longint unsigned QUOT_CAP = 64'd262144;

  typedef struct {
    logic [15:0] re;
    logic [15:0] im;
    logic        written;
    logic        clipped;
    logic [11:0] sc;
    logic [3:0]  sym;
    logic [15:0] grid;
    logic [15:0] nvar;
  } pilot_est_t;

  class estimate_board;
    logic [12:0] sc_count  = pce_pkg::SC_COUNT_RESET;
    logic [3:0]  sym_count = pce_pkg::SYM_COUNT_RESET;
    logic        mmse_en   = 1'b0;
    logic [15:0] noise_pwr = 16'd0;
    int          sc_pos    = 0;
    int          sym_pos   = 0;
    int unsigned weight    = pce_pkg::WEIGHT_ONE;
    pilot_est_t  expected_est[$];
    int          errors    = 0;

    function void write_reg(logic [1:0] idx, logic [15:0] v);
      case (idx)
        pce_pkg::REG_SUBCARRIER_COUNT: sc_count = v[12:0];
        pce_pkg::REG_SYMBOL_COUNT:     sym_count = v[3:0];
        pce_pkg::REG_MMSE_ENABLE:      mmse_en = v[0];
        pce_pkg::REG_NOISE_LEVEL:      noise_pwr = v;
        default: ;
      endcase
    endfunction

    // |num|*w/(8*den), one extra quotient bit, rounded half away from zero, clipped to Q3.12
    function logic [15:0] scale_part(longint num, longint unsigned den,
                                     longint unsigned w, inout bit clip);
      longint unsigned mag, prod, dd, q, r, rnd;
      mag = (num < 0) ? -num : num;
      prod = mag * w;
      dd = den << 3;
      q = prod / dd;
      r = prod % dd;
      if (q > QUOT_CAP) q = QUOT_CAP;
      q = q << 1;
      r = r << 1;
      if (r >= dd) begin
        r = r - dd;
        q = q + 1;
      end
      if (q > QUOT_CAP) q = QUOT_CAP;
      rnd = (q + 1) >> 1;
      if (num < 0) begin
        if (rnd > pce_pkg::EST_NEG_LIM) begin
          rnd = pce_pkg::EST_NEG_LIM;
          clip = 1'b1;
        end
        return 16'(64'd0 - rnd);
      end
      if (rnd > pce_pkg::EST_POS_LIM) begin
        rnd = pce_pkg::EST_POS_LIM;
        clip = 1'b1;
      end
      return 16'(rnd);
    endfunction

    function void note_pilot(logic [63:0] d, logic last);
      longint xr, xi, yr, yi, nr, ni;
      longint unsigned den, w;
      int scn, syn;
      bit mm, clip;
      pilot_est_t e;
      xr = longint'($signed(d[15:0]));
      xi = longint'($signed(d[31:16]));
      yr = longint'($signed(d[47:32]));
      yi = longint'($signed(d[63:48]));
      scn = (sc_count == 0) ? 1 :
            (sc_count > pce_pkg::MAX_SC) ? int'(pce_pkg::MAX_SC) : int'(sc_count);
      syn = (sym_count == 0) ? 1 :
            (sym_count > pce_pkg::MAX_SYM) ? int'(pce_pkg::MAX_SYM) : int'(sym_count);
      if (sc_pos >= scn) sc_pos = 0;
      if (sym_pos >= syn) sym_pos = 0;
      mm = mmse_en && (noise_pwr != 0);
      if (mm) weight = (32'd16777216 / (32'd256 + 32'(noise_pwr)) + 32'd1) >> 1;
      w = mm ? weight : pce_pkg::WEIGHT_ONE;
      den = xr * xr + xi * xi;
      clip = 1'b0;
      e.sc = 12'(sc_pos);
      e.sym = 4'(sym_pos);
      e.grid = 16'(sc_pos * syn + sym_pos);
      if (den == 0) begin
        e.re = '0;
        e.im = '0;
        e.written = 1'b0;
        e.nvar = '0;
        e.clipped = 1'b0;
      end else begin
        nr = yr * xr + yi * xi;
        ni = yi * xr - yr * xi;
        e.re = scale_part(nr, den, w, clip);
        e.im = scale_part(ni, den, w, clip);
        e.written = 1'b1;
        e.nvar = mm ? noise_pwr : pce_pkg::LS_VARIANCE;
        e.clipped = clip;
      end
      expected_est.push_back(e);
      if (last) begin
        sc_pos = 0;
        sym_pos = 0;
      end else begin
        sc_pos++;
        if (sc_pos >= scn) begin
          sc_pos = 0;
          sym_pos++;
          if (sym_pos >= syn) sym_pos = 0;
        end
      end
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void cmp(string nm, logic [15:0] want, logic [15:0] got);
      if (want !== got) flag($sformatf("%s mismatch: expected %0h, got %0h", nm, want, got));
    endfunction

    function void check_estimate(logic [79:0] td, logic [1:0] tu);
      pilot_est_t e;
      if (expected_est.size() == 0) begin
        flag("estimate word with no pilot outstanding");
        return;
      end
      e = expected_est.pop_front();
      cmp("est_real", e.re, td[15:0]);
      cmp("est_imag", e.im, td[31:16]);
      cmp("subcarrier_index", 16'(e.sc), 16'(td[43:32]));
      cmp("symbol_index", 16'(e.sym), 16'(td[47:44]));
      cmp("grid_index", e.grid, td[63:48]);
      cmp("noise_variance", e.nvar, td[79:64]);
      cmp("written", 16'(e.written), 16'(tu[0]));
      cmp("saturated", 16'(e.clipped), 16'(tu[1]));
    endfunction

    function int pending();
      return expected_est.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [1:0]  m_tuser;

  estimate_board board = new;
  bit steady = 1'b0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  pilot_channel_estimator_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) board.note_pilot(s_tdata, s_tlast);
    if (!rst && m_tvalid && m_tready) board.check_estimate(m_tdata, m_tuser);
  end

  // receiver: random backpressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= 400;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= 36);
    end
  end

  task automatic send_pilot(input logic [63:0] d, input logic last);
    while (!steady && $urandom_range(99) < 36) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= v;
    board.write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] sc, input logic [15:0] sym,
                            input logic [15:0] en, input logic [15:0] np);
    drain();
    write_reg(pce_pkg::REG_SUBCARRIER_COUNT, sc);
    write_reg(pce_pkg::REG_SYMBOL_COUNT, sym);
    write_reg(pce_pkg::REG_MMSE_ENABLE, en);
    write_reg(pce_pkg::REG_NOISE_LEVEL, np);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] pick_pilot();
    logic [15:0] xr, xi, yr, yi;
    int k, t;
    k = $urandom_range(99);
    xr = $urandom;
    xi = $urandom;
    yr = $urandom;
    yi = $urandom;
    if (k < 6) begin
      xr = '0;
      xi = '0;
    end else if (k < 45) begin
      // QPSK pilot with a noisy receive sample
      xr = $urandom_range(1) ? 16'sd11585 : -16'sd11585;
      xi = $urandom_range(1) ? 16'sd11585 : -16'sd11585;
      t = int'($signed(xr)) + int'($urandom_range(8000)) - 4000;
      yr = 16'(t);
      t = int'($signed(xi)) + int'($urandom_range(8000)) - 4000;
      yi = 16'(t);
    end else if (k < 60) begin
      xr = 16'(int'($urandom_range(63)) - 32);
      xi = 16'(int'($urandom_range(63)) - 32);
    end
    return {yi, yr, xi, xr};
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default grid, least squares
    send_pilot({16'h0000, 16'h4000, 16'h0000, 16'h4000}, 1'b0);
    send_pilot({16'h8000, 16'h7FFF, 16'h8000, 16'h8000}, 1'b0);
    send_pilot({16'h7FFF, 16'h7FFF, 16'h0000, 16'h0001}, 1'b0);
    send_pilot({16'h8000, 16'h8000, 16'h0000, 16'h0001}, 1'b0);
    send_pilot({16'hABCD, 16'h1234, 16'h0000, 16'h0000}, 1'b0);
    send_pilot({16'h7FFF, 16'h8000, 16'h0001, 16'h0000}, 1'b0);
    send_pilot({16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF}, 1'b0);
    send_pilot({16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1);
    send_pilot({16'h2D41, 16'h2D41, 16'hD2BF, 16'h2D41}, 1'b0);
    send_pilot({16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF}, 1'b0);
    // MMSE with zero noise falls back to least squares; then MMSE at noise levels 1 and FFFF
    set_config(16'd12, 16'd14, 16'd1, 16'd0);
    send_pilot({16'h0000, 16'h4000, 16'h0000, 16'h4000}, 1'b0);
    send_pilot({16'h1111, 16'h7FFF, 16'h0000, 16'h0000}, 1'b0);
    set_config(16'd12, 16'd14, 16'd1, 16'd1);
    send_pilot({16'h0000, 16'h4000, 16'h0000, 16'h4000}, 1'b0);
    send_pilot({16'h7FFF, 16'h7FFF, 16'h0000, 16'h0001}, 1'b0);
    set_config(16'd12, 16'd14, 16'd1, 16'hFFFF);
    send_pilot({16'h0000, 16'h4000, 16'h0000, 16'h4000}, 1'b0);
    send_pilot({16'h8000, 16'h8000, 16'h0000, 16'h0001}, 1'b1);

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_config(16'd1, 16'd1, 16'd0, 16'd0);
        1: set_config(16'd0, 16'd0, 16'd1, 16'hFFFF);
        2: set_config(16'hFFFF, 16'hFFFF, 16'd1, 16'd1);
        3: set_config(16'd4096, 16'd14, 16'd0, 16'd12345);
        5: set_config(16'd3, 16'd5, 16'd1, 16'd0);
        default: set_config(16'($urandom_range(20, 1)), 16'($urandom_range(15, 0)),
                            16'($urandom_range(1)), 16'($urandom));
      endcase
      if (ph == 4) hold_seq <= hold_seq + 1;
      steady = (ph == 6);
      repeat (190) send_pilot(pick_pilot(), $urandom_range(99) < 4);
    end
    steady = 1'b0;

    drain();
    repeat (60) @(posedge clk);
    if (board.errors == 0) begin
      $display("pilot_channel_estimator_core_tb: done, clean");
    end else begin
      $display("pilot_channel_estimator_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("pilot_channel_estimator_core_tb: done, errors");
    $finish;
  end

endmodule
`default_nettype wire

// ----- pilot_channel_estimator_core.f -----
rtl/pce_pkg.sv
rtl/pce_serial_mul.sv
rtl/pce_serial_div.sv
rtl/pce_position.sv
rtl/pilot_channel_estimator_core.sv
tb/sv/pilot_channel_estimator_core_tb.sv
